// ===== hw/rtl/bmp_pkg.sv =====
package bmp_pkg;

    // field and datapath widths
    localparam int WORD_W = 31;
    localparam int N_W    = 16;
    localparam int CNT_W  = 5;

    // serial step counts of the modular multiplier
    localparam logic [CNT_W-1:0] STEPS_WIDE   = 5'd31;
    localparam logic [CNT_W-1:0] STEPS_NARROW = 5'd16;

    // set size limit and modulus after reset
    localparam logic [31:0]       MAX_N         = 32'd65535;
    localparam logic [WORD_W-1:0] RESET_MODULUS = 31'd1000000007;

    // command to one modular multiplier
    typedef struct packed {
        logic start;
        logic wide;     // 31-bit serial operand, else 16-bit
    } mm_cmd_t;

endpackage

// ===== hw/rtl/bmp_modmul.sv =====
// bit-serial interleaved modular multiplier, msb first
module bmp_modmul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bmp_pkg::mm_cmd_t            cmd,
    input  logic [bmp_pkg::WORD_W-1:0]  ser_op,
    input  logic [bmp_pkg::WORD_W-1:0]  par_op,
    input  logic [bmp_pkg::WORD_W-1:0]  modulus,
    output logic                        done,
    output logic [bmp_pkg::WORD_W-1:0]  product
);

    logic                          busy_reg,  busy_next;
    logic                          done_reg,  done_next;
    logic [bmp_pkg::CNT_W-1:0]     cnt_reg,   cnt_next;
    logic [bmp_pkg::WORD_W-1:0]    ser_reg,   ser_next;
    logic [bmp_pkg::WORD_W-1:0]    par_reg,   par_next;
    logic [bmp_pkg::WORD_W-1:0]    acc_reg,   acc_next;

    logic [bmp_pkg::WORD_W+1:0]    sum;
    logic [bmp_pkg::WORD_W+2:0]    diff1;
    logic [bmp_pkg::WORD_W+2:0]    diff2;

    // 2*acc + bit*par stays below 3*m, so subtract m or 2*m at most
    always_comb
    begin
        sum   = {1'b0, acc_reg, 1'b0}
              + (ser_reg[bmp_pkg::WORD_W-1] ? {2'b00, par_reg} : '0);
        diff1 = {1'b0, sum} - {3'b000, modulus};
        diff2 = {1'b0, sum} - {2'b00, modulus, 1'b0};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        ser_next  = ser_reg;
        par_next  = par_reg;
        acc_next  = acc_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            acc_next  = '0;
            par_next  = par_op;
            if (cmd.wide)
            begin
                ser_next = ser_op;
                cnt_next = bmp_pkg::STEPS_WIDE;
            end
            else
            begin
                ser_next = {ser_op[bmp_pkg::N_W-1:0],
                            {(bmp_pkg::WORD_W-bmp_pkg::N_W){1'b0}}};
                cnt_next = bmp_pkg::STEPS_NARROW;
            end
        end
        else if (busy_reg)
        begin
            if (!diff2[bmp_pkg::WORD_W+2])
                acc_next = diff2[bmp_pkg::WORD_W-1:0];
            else if (!diff1[bmp_pkg::WORD_W+2])
                acc_next = diff1[bmp_pkg::WORD_W-1:0];
            else
                acc_next = sum[bmp_pkg::WORD_W-1:0];
            ser_next = {ser_reg[bmp_pkg::WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ser_reg <= ser_next;
        par_reg <= par_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== hw/rtl/binomial_mod_prime.sv =====
// trivial words (r > n, r = 0, r = n, modulus below two) go straight to the output
// otherwise k = min(r, n-r) loop steps, one exponent step per bit of p-2, then a final product
// throughput: one word at a time, set by the 1-bit-per-cycle modular multipliers
// slowest word: n = 65535, r = 32767
// reset: async active low, idle, output empty, modulus back to 1000000007
module binomial_mod_prime (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [bmp_pkg::WORD_W-1:0]  cfg_wr_data,
    // input words
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [bmp_pkg::N_W-1:0]     set_size,
    input  logic [bmp_pkg::N_W-1:0]     choose_count,
    // result words
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [bmp_pkg::WORD_W-1:0]  binomial_residue
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOP_GO,
        S_LOOP_WAIT,
        S_EXP_GO,
        S_EXP_WAIT,
        S_FIN_GO,
        S_FIN_WAIT,
        S_DONE
    } state_t;

    state_t                        state_reg,   state_next;
    logic [bmp_pkg::WORD_W-1:0]    modulus_reg, modulus_next;
    logic [bmp_pkg::N_W-1:0]       n_reg,       n_next;
    logic [bmp_pkg::N_W-1:0]       r_reg,       r_next;     // min(r, n-r)
    logic [bmp_pkg::N_W-1:0]       i_reg,       i_next;
    logic [bmp_pkg::WORD_W-1:0]    num_reg,     num_next;   // falling product
    logic [bmp_pkg::WORD_W-1:0]    den_reg,     den_next;   // denominator, then base
    logic [bmp_pkg::WORD_W-1:0]    pow_reg,     pow_next;   // inverse accumulator
    logic [bmp_pkg::WORD_W-1:0]    exp_reg,     exp_next;   // p-2, shifted lsb first
    logic [bmp_pkg::WORD_W-1:0]    res_reg,     res_next;
    logic                          ovalid_reg,  ovalid_next;
    logic [bmp_pkg::WORD_W-1:0]    ores_reg,    ores_next;

    // multiplier hookup
    bmp_pkg::mm_cmd_t              cmd_a, cmd_b;
    logic [bmp_pkg::WORD_W-1:0]    ser_a, par_a, ser_b, par_b;
    logic                          done_a, done_b;
    logic [bmp_pkg::WORD_W-1:0]    prod_a, prod_b;

    // incoming word decode
    logic [bmp_pkg::N_W-1:0]       n_sat;
    logic [bmp_pkg::N_W-1:0]       n_minus_r;
    logic [bmp_pkg::N_W-1:0]       i_inc;
    logic                          accept;

    // unit a: numerator, pow*base, final product; unit b: denominator, base*base
    bmp_modmul u_mm_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_a),
        .ser_op  (ser_a),
        .par_op  (par_a),
        .modulus (modulus_reg),
        .done    (done_a),
        .product (prod_a)
    );

    bmp_modmul u_mm_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_b),
        .ser_op  (ser_b),
        .par_op  (par_b),
        .modulus (modulus_reg),
        .done    (done_b),
        .product (prod_b)
    );

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // clamp set size to the limit
    always_comb
    begin
        if ({{(32-bmp_pkg::N_W){1'b0}}, set_size} > bmp_pkg::MAX_N)
            n_sat = bmp_pkg::MAX_N[bmp_pkg::N_W-1:0];
        else
            n_sat = set_size;
        n_minus_r = n_sat - choose_count;
    end

    assign i_inc = i_reg + 1'b1;

    // multiplier operand routing per phase
    always_comb
    begin
        cmd_a = '0;
        cmd_b = '0;
        ser_a = '0;
        par_a = '0;
        ser_b = '0;
        par_b = '0;
        case (state_reg)
            S_LOOP_GO:
            begin
                // num * (n - i) and den * (i + 1), 16-bit serial operands
                cmd_a.start = 1'b1;
                cmd_b.start = 1'b1;
                ser_a = {{(bmp_pkg::WORD_W-bmp_pkg::N_W){1'b0}}, n_reg - i_reg};
                par_a = num_reg;
                ser_b = {{(bmp_pkg::WORD_W-bmp_pkg::N_W){1'b0}}, i_inc};
                par_b = den_reg;
            end
            S_EXP_GO:
            begin
                // pow * base and base * base from the same base
                cmd_a = '{start: exp_reg != '0, wide: 1'b1};
                cmd_b = '{start: exp_reg != '0, wide: 1'b1};
                ser_a = den_reg;
                par_a = pow_reg;
                ser_b = den_reg;
                par_b = den_reg;
            end
            S_FIN_GO:
            begin
                cmd_a = '{start: 1'b1, wide: 1'b1};
                ser_a = pow_reg;
                par_a = num_reg;
            end
            default:
            begin
                cmd_a = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        modulus_next = modulus_reg;
        n_next       = n_reg;
        r_next       = r_reg;
        i_next       = i_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        pow_next     = pow_reg;
        exp_next     = exp_reg;
        res_next     = res_reg;
        ovalid_next  = ovalid_reg;
        ores_next    = ores_reg;

        if (cfg_wr_en)
            modulus_next = cfg_wr_data;

        // output word taken
        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next   = n_sat;
                    i_next   = '0;
                    num_next = {{(bmp_pkg::WORD_W-1){1'b0}}, 1'b1};
                    den_next = {{(bmp_pkg::WORD_W-1){1'b0}}, 1'b1};
                    if (choose_count > n_minus_r)
                        r_next = n_minus_r;
                    else
                        r_next = choose_count;
                    if (modulus_reg < 31'd2 || choose_count > n_sat)
                    begin
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                    else if (choose_count == '0 || choose_count == n_sat)
                    begin
                        res_next   = {{(bmp_pkg::WORD_W-1){1'b0}}, 1'b1};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LOOP_GO;
                    end
                end
            end
            S_LOOP_GO:
            begin
                state_next = S_LOOP_WAIT;
            end
            S_LOOP_WAIT:
            begin
                if (done_a)
                begin
                    num_next = prod_a;
                    den_next = prod_b;
                    i_next   = i_inc;
                    if (i_inc == r_reg)
                    begin
                        // fermat inverse: den^(p-2)
                        pow_next   = {{(bmp_pkg::WORD_W-1){1'b0}}, 1'b1};
                        exp_next   = modulus_reg - 31'd2;
                        state_next = S_EXP_GO;
                    end
                    else
                    begin
                        state_next = S_LOOP_GO;
                    end
                end
            end
            S_EXP_GO:
            begin
                if (exp_reg == '0)
                    state_next = S_FIN_GO;
                else
                    state_next = S_EXP_WAIT;
            end
            S_EXP_WAIT:
            begin
                if (done_a)
                begin
                    if (exp_reg[0])
                        pow_next = prod_a;
                    den_next   = prod_b;
                    exp_next   = {1'b0, exp_reg[bmp_pkg::WORD_W-1:1]};
                    state_next = S_EXP_GO;
                end
            end
            S_FIN_GO:
            begin
                state_next = S_FIN_WAIT;
            end
            S_FIN_WAIT:
            begin
                if (done_a)
                begin
                    res_next   = prod_a;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hand over once the output register is free
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    ores_next   = res_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            modulus_reg <= bmp_pkg::RESET_MODULUS;
            ovalid_reg  <= 1'b0;
            ores_reg    <= '0;
            n_reg       <= '0;
            r_reg       <= '0;
            i_reg       <= '0;
            num_reg     <= '0;
            den_reg     <= '0;
            pow_reg     <= '0;
            exp_reg     <= '0;
            res_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            modulus_reg <= modulus_next;
            ovalid_reg  <= ovalid_next;
            ores_reg    <= ores_next;
            n_reg       <= n_next;
            r_reg       <= r_next;
            i_reg       <= i_next;
            num_reg     <= num_next;
            den_reg     <= den_next;
            pow_reg     <= pow_next;
            exp_reg     <= exp_next;
            res_reg     <= res_next;
        end
    end

    assign out_valid        = ovalid_reg;
    assign binomial_residue = ores_reg;

    // an accepted word always makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("block not busy after accepting a word");

    // results are fully reduced
    a_residue_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && modulus_reg >= 31'd2 |-> binomial_residue < modulus_reg)
        else $error("result not reduced by the modulus");

    // both multipliers finish together in the loop and exponent phases
    a_units_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOP_WAIT || state_reg == S_EXP_WAIT) |-> done_a == done_b)
        else $error("multipliers out of step");

    // the loop index never passes the reduced choose count
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOOP_WAIT |-> i_reg < r_reg)
        else $error("loop index past choose count");

endmodule

// ===== tb/testbench.sv =====
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // largest prime that fits the 31-bit modulus register
    localparam logic [bmp_pkg::WORD_W-1:0] MERSENNE_31 = 31'd2147483647;

    // one row of directed stimulus: modulus in force, the word, and a typed answer if known
    typedef struct packed {
        logic [bmp_pkg::WORD_W-1:0] modulus;
        logic [bmp_pkg::N_W-1:0]    n;
        logic [bmp_pkg::N_W-1:0]    r;
        bit                         typed;
        logic [bmp_pkg::WORD_W-1:0] residue;
    } choice_row_t;

    // run limits; the slowest word is the one with the full-length product loop
    localparam int CYCLE_LIMIT = 4000000;
    localparam int TAIL_CYCLES = 100;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 12;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [bmp_pkg::WORD_W-1:0]   cfg_wr_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [bmp_pkg::N_W-1:0]      set_size = '0;
    logic [bmp_pkg::N_W-1:0]      choose_count = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [bmp_pkg::WORD_W-1:0]   binomial_residue;

    // residues still owed by the block, oldest first
    logic [bmp_pkg::WORD_W-1:0]   residue_due [$];
    // modulus the block holds right now
    logic [bmp_pkg::WORD_W-1:0]   live_modulus = bmp_pkg::RESET_MODULUS;
    int                           fault_count = 0;
    int                           cycle_count = 0;
    int                           stall_left = 0;
    // no idling on either side once set
    bit                           quiet = 1'b0;

    // directed rows: trivial answers, extremes, tiny and degenerate moduli
    choice_row_t directed_rows [22] = '{
        '{bmp_pkg::RESET_MODULUS, 16'd5,     16'd2,     1'b1, 31'd10},
        '{bmp_pkg::RESET_MODULUS, 16'd0,     16'd0,     1'b1, 31'd1},
        '{bmp_pkg::RESET_MODULUS, 16'd3,     16'd7,     1'b1, 31'd0},
        '{bmp_pkg::RESET_MODULUS, 16'd0,     16'd65535, 1'b1, 31'd0},
        '{bmp_pkg::RESET_MODULUS, 16'd65535, 16'd0,     1'b1, 31'd1},
        '{bmp_pkg::RESET_MODULUS, 16'd65535, 16'd65535, 1'b1, 31'd1},
        '{bmp_pkg::RESET_MODULUS, 16'd65535, 16'd1,     1'b1, 31'd65535},
        '{bmp_pkg::RESET_MODULUS, 16'd65535, 16'd65534, 1'b1, 31'd65535},
        '{bmp_pkg::RESET_MODULUS, 16'd10,    16'd3,     1'b1, 31'd120},
        // the one full-length word, longest product loop there is
        '{bmp_pkg::RESET_MODULUS, 16'd65535, 16'd32767, 1'b0, 31'd0},
        '{bmp_pkg::RESET_MODULUS, 16'd1000,  16'd37,    1'b0, 31'd0},
        // modulus below two answers zero, trivial words too
        '{31'd0,                  16'd5,     16'd2,     1'b1, 31'd0},
        '{31'd0,                  16'd4,     16'd4,     1'b1, 31'd0},
        '{31'd1,                  16'd0,     16'd0,     1'b1, 31'd0},
        '{31'd1,                  16'd9,     16'd4,     1'b1, 31'd0},
        // modulus two: exponent is zero, answer is numerator mod 2
        '{31'd2,                  16'd3,     16'd1,     1'b1, 31'd1},
        '{31'd2,                  16'd7,     16'd3,     1'b0, 31'd0},
        // denominator product vanishes mod 7
        '{31'd7,                  16'd14,    16'd7,     1'b1, 31'd0},
        '{31'd7,                  16'd20,    16'd9,     1'b0, 31'd0},
        '{MERSENNE_31,            16'd65535, 16'd2,     1'b1, 31'd2147385345},
        '{MERSENNE_31,            16'd65535, 16'd3,     1'b0, 31'd0},
        // composite modulus, same steps regardless
        '{31'd1000,               16'd10,    16'd4,     1'b0, 31'd0}
    };

    binomial_mod_prime uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .set_size         (set_size),
        .choose_count     (choose_count),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .binomial_residue (binomial_residue)
    );

    always #10 clk = ~clk;

    // C(n,r) mod p the way the block computes it, Fermat inverse included
    function automatic logic [bmp_pkg::WORD_W-1:0] binom_mod(
        logic [bmp_pkg::N_W-1:0]    n_in,
        logic [bmp_pkg::N_W-1:0]    r_in,
        logic [bmp_pkg::WORD_W-1:0] p);
        longint unsigned n;
        longint unsigned r;
        longint unsigned m;
        longint unsigned numer;
        longint unsigned denom;
        longint unsigned base;
        longint unsigned expo;
        longint unsigned acc;
        longint unsigned i;
        longint unsigned res;
        n = n_in;
        r = r_in;
        m = p;
        if (n > bmp_pkg::MAX_N)
            n = bmp_pkg::MAX_N;
        if (m < 2)
            return '0;
        if (r > n)
            return '0;
        if (r == 0 || r == n)
            return 31'd1;
        // use the shorter side of the symmetry
        if (r > n / 2)
            r = n - r;
        numer = 1;
        denom = 1;
        for (i = 0; i < r; i++)
        begin
            numer = (numer * (n - i)) % m;
            denom = (denom * (i + 1)) % m;
        end
        // denom^(p-2) by square and multiply
        base = denom % m;
        expo = m - 2;
        acc = 1;
        while (expo > 0)
        begin
            if ((expo & 1) != 0)
                acc = (acc * base) % m;
            base = (base * base) % m;
            expo = expo >> 1;
        end
        res = (numer * acc) % m;
        return res[bmp_pkg::WORD_W-1:0];
    endfunction

    // offer one word, optionally after an idle burst, and log what it should give
    task automatic send_choice(logic [bmp_pkg::N_W-1:0] n, logic [bmp_pkg::N_W-1:0] r,
                               bit typed, logic [bmp_pkg::WORD_W-1:0] residue);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        set_size     <= n;
        choose_count <= r;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        // accepted at this edge; valid stays up in case another word follows
        if (typed)
            residue_due.push_back(residue);
        else
            residue_due.push_back(binom_mod(n, r, live_modulus));
    endtask

    // stop offering and wait until every owed residue is back
    task automatic settle();
        in_valid <= 1'b0;
        while (residue_due.size() != 0)
            @(posedge clk);
    endtask

    // modulus only changes with the block idle
    task automatic write_modulus(logic [bmp_pkg::WORD_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        live_modulus = value;
    endtask

    // random word: mostly short product loops, some trivial and some out of range
    task automatic random_choice();
        int mode;
        int n;
        int k;
        int r;
        mode = $urandom_range(0, 9);
        if (mode <= 5)
        begin
            // nontrivial, k kept short, either side of the symmetry
            n = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 65535) : $urandom_range(2, 200);
            k = $urandom_range(1, (n - 1 < 40) ? n - 1 : 40);
            r = ($urandom_range(0, 1) == 0) ? k : n - k;
        end
        else if (mode == 6)
        begin
            // r above n
            n = $urandom_range(0, 65534);
            r = $urandom_range(n + 1, 65535);
        end
        else if (mode == 7)
        begin
            n = $urandom_range(0, 65535);
            r = ($urandom_range(0, 1) == 0) ? 0 : n;
        end
        else if (mode == 8)
        begin
            // somewhat longer loop now and then
            n = $urandom_range(600, 65535);
            k = $urandom_range(41, 300);
            r = ($urandom_range(0, 1) == 0) ? k : n - k;
        end
        else
        begin
            n = $urandom_range(0, 20);
            r = $urandom_range(0, 20);
        end
        send_choice(n[bmp_pkg::N_W-1:0], r[bmp_pkg::N_W-1:0], 1'b0, '0);
    endtask

    // result side stalls in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 5);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // compare each accepted residue with the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (residue_due.size() == 0)
            begin
                $error("binomial_residue: expected none, actual %0d", binomial_residue);
                fault_count++;
            end
            else
            begin
                if (binomial_residue !== residue_due[0])
                begin
                    $error("binomial_residue: expected %0d, actual %0d",
                           residue_due[0], binomial_residue);
                    fault_count++;
                end
                void'(residue_due.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        logic [bmp_pkg::WORD_W-1:0] phase_modulus [PHASES];
        int unsigned                rand_word;
        int                         ph;
        int                         w;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, modulus starts at its reset value
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].modulus != live_modulus)
                write_modulus(directed_rows[i].modulus);
            send_choice(directed_rows[i].n, directed_rows[i].r,
                        directed_rows[i].typed, directed_rows[i].residue);
        end

        // random part, one modulus per phase, last phase without idling
        rand_word = $urandom();
        phase_modulus[0] = bmp_pkg::RESET_MODULUS;
        phase_modulus[1] = 31'd13;
        phase_modulus[2] = MERSENNE_31;
        phase_modulus[3] = 31'd2;
        phase_modulus[4] = rand_word[bmp_pkg::WORD_W-1:0];
        phase_modulus[5] = 31'd3 + 31'($urandom_range(0, 397));
        phase_modulus[6] = 31'd1;
        phase_modulus[7] = 31'd65537;
        for (ph = 0; ph < PHASES; ph++)
        begin
            write_modulus(phase_modulus[ph]);
            if (ph == PHASES - 1)
                quiet = 1'b1;
            for (w = 0; w < PHASE_WORDS; w++)
                random_choice();
        end

        settle();
        // keep watching for stray words after the last one owed
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
